>>> src/kcrs_pkg.sv
// Package for the keyed counter RNG stream table.
// Types, codes and mixer constants; no dependencies.
package kcrs_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;
    localparam int DEFAULT_KEY_BITS      = 16;
    localparam int STREAM_KEY_W          = 16;
    localparam int WORD_W                = 64;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_PREVIEW = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_MISSING   = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    // multiplier pass of the mixer
    typedef enum logic [1:0] {
        PH_GOLDEN = 2'd0,
        PH_MUL_A  = 2'd1,
        PH_MUL_B  = 2'd2
    } mix_phase_t;

    function automatic logic [63:0] mix_const(input mix_phase_t ph);
        logic [63:0] c;
        begin
            case (ph)
                PH_GOLDEN: c = GOLDEN_STEP;
                PH_MUL_A:  c = MIX_MUL_A;
                PH_MUL_B:  c = MIX_MUL_B;
                default:   c = GOLDEN_STEP;
            endcase
            return c;
        end
    endfunction

endpackage

>>> src/kcrs_if.sv
// Request and response channel interfaces for the stream table.
// Depends on kcrs_pkg.
interface kcrs_req_if;
    import kcrs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [STREAM_KEY_W-1:0]   stream_key;
    logic [WORD_W-1:0]         new_seed;
    logic [WORD_W-1:0]         expected_count;
    logic [WORD_W-1:0]         advance_by;
    logic [WORD_W-1:0]         lookahead;
    modport source (output valid, op, stream_key, new_seed, expected_count, advance_by,
                    lookahead, input ready);
    modport sink   (input valid, op, stream_key, new_seed, expected_count, advance_by,
                    lookahead, output ready);
endinterface

interface kcrs_rsp_if #(parameter int COUNT_W = 5);
    import kcrs_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [WORD_W-1:0]  random_value;
    logic [COUNT_W-1:0] entries_used;
    modport source (output valid, status, random_value, entries_used, input ready);
    modport sink   (input valid, status, random_value, entries_used, output ready);
endinterface

>>> src/keyed_counter_rng_stream_table_core.sv
// Top level of the keyed counter RNG stream table (splitmix64 previews).
// Depends on kcrs_pkg and the interfaces in kcrs_if.sv.
//
// Usage
//   req: one request word per handshake (op, stream_key, new_seed, expected_count,
//        advance_by, lookahead). Accepted when valid and ready are high at a clock edge.
//   rsp: one response word per request (status, random_value, entries_used).
//   Requests are processed one at a time. Keys and valid bits sit in flops and are
//   matched in parallel; seed and draw count live in one synchronous RAM whose read
//   is registered, then modified and written back. Create, advance, clear and failed
//   previews pass through the find, eval and response states. A successful preview
//   also runs three 64x64 low products, each done as three passes of a shared
//   32x32 multiplier plus a fold step.
//   The response sits in an output register; the next request is taken while it
//   waits, and its own result is held back until the register is free.
//   Reset clears all valid bits and the use count at once (no RAM sweep); RAM
//   contents are only read behind a set valid bit.
//   A stalled receiver stalls the pipeline after at most one extra request.
module keyed_counter_rng_stream_table_core
#(
    parameter int TABLE_ENTRIES = kcrs_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int KEY_BITS      = kcrs_pkg::DEFAULT_KEY_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    kcrs_req_if.sink   req,
    kcrs_rsp_if.source rsp
);
    import kcrs_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KW      = (KEY_BITS < STREAM_KEY_W) ? KEY_BITS : STREAM_KEY_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIND = 6'b000010,
        S_EVAL = 6'b000100,
        S_MUL  = 6'b001000,
        S_RESP = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // table state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [KW-1:0]            key_reg [TABLE_ENTRIES];
    logic [2*WORD_W-1:0]      mem [TABLE_ENTRIES];    // {seed, draws}
    logic [2*WORD_W-1:0]      rd_data_reg;
    logic [COUNT_W-1:0]       used_reg;

    // request latch
    op_t               op_reg;
    logic [KW-1:0]     rkey_reg;
    logic [WORD_W-1:0] seed_reg, exp_reg, by_reg, ahead_reg;

    // lookup results
    logic              hit_reg, full_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg;
    logic              hit_c;
    logic [IDX_W-1:0]  hit_idx_c, free_idx_c;

    // mixer
    mix_phase_t        phase_reg;
    logic [1:0]        step_reg;
    logic [WORD_W-1:0] opnd_reg, acc_reg, mseed_reg;
    logic [31:0]       mul_x, mul_y;
    logic [63:0]       mul_p, konst;

    // response
    status_t           status_reg;
    logic [WORD_W-1:0] value_reg;
    logic              out_valid_reg;
    logic [2:0]        o_status_reg;
    logic [WORD_W-1:0] o_value_reg;
    logic [COUNT_W-1:0] o_used_reg;

    // evaluation
    logic [WORD_W-1:0] draws_c, mseed_c;
    logic [WORD_W:0]   adv_sum_c, look_sum_c;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.status = o_status_reg;
    assign rsp.random_value = o_value_reg;
    assign rsp.entries_used = o_used_reg;

    // parallel key match; lowest hit and lowest free slot
    always_comb
    begin
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        free_idx_c = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == rkey_reg)
            begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!valid_reg[i])
                free_idx_c = IDX_W'(i);
        end
    end

    assign draws_c    = rd_data_reg[WORD_W-1:0];
    assign mseed_c    = rd_data_reg[2*WORD_W-1:WORD_W];
    assign adv_sum_c  = {1'b0, draws_c} + {1'b0, by_reg};
    assign look_sum_c = {1'b0, draws_c} + {1'b0, ahead_reg};

    // shared 32x32 multiplier: lo*lo, hi*lo, lo*hi
    assign konst = mix_const(phase_reg);
    assign mul_x = (step_reg == 2'd1) ? opnd_reg[63:32] : opnd_reg[31:0];
    assign mul_y = (step_reg == 2'd2) ? konst[63:32] : konst[31:0];
    assign mul_p = {32'b0, mul_x} * {32'b0, mul_y};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.valid) state_next = S_FIND;
            S_FIND: state_next = S_EVAL;
            S_EVAL:
            begin
                if (op_reg == OP_PREVIEW && rkey_reg != '0 && hit_reg && !look_sum_c[WORD_W])
                    state_next = S_MUL;
                else
                    state_next = S_RESP;
            end
            S_MUL:
                if (phase_reg == PH_MUL_B && step_reg == 2'd3) state_next = S_RESP;
            S_RESP:
                if (!out_valid_reg || rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EVAL)
            begin
                if (op_reg == OP_CREATE && rkey_reg != '0 && !hit_reg && !full_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    used_reg <= used_reg + COUNT_W'(1);
                end
                else if (op_reg == OP_CLEAR)
                begin
                    valid_reg <= '0;
                    used_reg  <= '0;
                end
            end
            if (state_reg == S_RESP && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath; RAM contents and payload need no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            op_reg    <= op_t'(req.op);
            rkey_reg  <= req.stream_key[KW-1:0];
            seed_reg  <= req.new_seed;
            exp_reg   <= req.expected_count;
            by_reg    <= req.advance_by;
            ahead_reg <= req.lookahead;
        end
        if (state_reg == S_FIND)
        begin
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            free_idx_reg <= free_idx_c;
            full_reg     <= &valid_reg;
            rd_data_reg  <= mem[hit_idx_c];
        end
        if (state_reg == S_EVAL)
        begin
            value_reg <= '0;
            phase_reg <= PH_GOLDEN;
            step_reg  <= 2'd0;
            mseed_reg <= mseed_c;
            opnd_reg  <= look_sum_c[WORD_W-1:0] + 64'd1;
            case (op_reg)
                OP_CREATE:
                begin
                    if (rkey_reg == '0)
                        status_reg <= ST_INVALID;
                    else if (hit_reg)
                        status_reg <= ST_DUPLICATE;
                    else if (full_reg)
                        status_reg <= ST_FULL;
                    else
                    begin
                        status_reg <= ST_OK;
                        key_reg[free_idx_reg] <= rkey_reg;
                        mem[free_idx_reg] <= {seed_reg, 64'd0};
                    end
                end
                OP_ADVANCE:
                begin
                    if (rkey_reg == '0 || by_reg == '0)
                        status_reg <= ST_INVALID;
                    else if (!hit_reg)
                        status_reg <= ST_MISSING;
                    else if (draws_c != exp_reg)
                        status_reg <= ST_MISMATCH;
                    else if (adv_sum_c[WORD_W])
                        status_reg <= ST_OVERFLOW;
                    else
                    begin
                        status_reg <= ST_OK;
                        mem[hit_idx_reg] <= {mseed_c, adv_sum_c[WORD_W-1:0]};
                    end
                end
                OP_PREVIEW:
                begin
                    if (rkey_reg == '0 || !hit_reg)
                        status_reg <= ST_MISSING;
                    else if (look_sum_c[WORD_W])
                        status_reg <= ST_OVERFLOW;
                    else
                        status_reg <= ST_OK;
                end
                default: status_reg <= ST_OK;
            endcase
        end
        if (state_reg == S_MUL)
        begin
            step_reg <= step_reg + 2'd1;
            case (step_reg)
                2'd0: acc_reg <= mul_p;
                2'd1: acc_reg <= acc_reg + {mul_p[31:0], 32'b0};
                2'd2: acc_reg <= acc_reg + {mul_p[31:0], 32'b0};
                default:
                begin
                    // fold the product into the next operand
                    case (phase_reg)
                        PH_GOLDEN:
                        begin
                            opnd_reg  <= (acc_reg + mseed_reg)
                                         ^ ((acc_reg + mseed_reg) >> SHIFT_A);
                            phase_reg <= PH_MUL_A;
                        end
                        PH_MUL_A:
                        begin
                            opnd_reg  <= acc_reg ^ (acc_reg >> SHIFT_B);
                            phase_reg <= PH_MUL_B;
                        end
                        default: value_reg <= acc_reg ^ (acc_reg >> SHIFT_C);
                    endcase
                end
            endcase
        end
        if (state_reg == S_RESP && (!out_valid_reg || rsp.ready))
        begin
            o_status_reg <= status_reg;
            o_value_reg  <= value_reg;
            o_used_reg   <= used_reg;
        end
    end

    // use count tracks the valid bits
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == COUNT_W'($countones(valid_reg)))
        else $error("use count out of step with valid bits");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_W'(TABLE_ENTRIES))
        else $error("use count beyond table size");

    a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_FIND)
        else $error("accepted word did not start a lookup");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.random_value == '0)
        else $error("failed request carries a value");

endmodule
